[rtl/tpc_pkg.sv]
package tpc_pkg;

    // Widths of the internal distance and division datapath.
    localparam int unsigned COORD_W = 32;
    localparam int unsigned PROD_W  = 64;
    localparam int unsigned DIST_W  = 67;
    localparam int unsigned REM_W   = 68;
    localparam int unsigned FRAC_W  = 16;

    // Pipeline depth: two distance stages, one classify/divider load stage,
    // one stage per quotient bit, then the interpolation multiply and add.
    localparam int unsigned DIV_STEPS = FRAC_W;
    localparam int unsigned LAT       = 2 + 1 + DIV_STEPS + 2;

    localparam logic signed [COORD_W-1:0] NORMAL_Z_RESET = 32'sd65536;

    typedef enum logic [1:0] {
        REG_NORMAL_X     = 2'd0,
        REG_NORMAL_Y     = 2'd1,
        REG_NORMAL_Z     = 2'd2,
        REG_PLANE_OFFSET = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        CASE_NONE = 2'd0,
        CASE_ONE  = 2'd1,
        CASE_TWO  = 2'd2,
        CASE_ALL  = 2'd3
    } clip_case_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } vec_t;

    typedef vec_t [2:0] tri_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] nx;
        logic signed [COORD_W-1:0] ny;
        logic signed [COORD_W-1:0] nz;
        logic signed [COORD_W-1:0] d;
    } plane_t;

    typedef struct packed {
        tri_t         vert;
        logic [31:0]  colour;
        clip_case_t   kind;
        logic [1:0]   a0;
        logic [1:0]   b0;
        logic [1:0]   a1;
        logic [1:0]   b1;
    } ctx_t;

endpackage

[rtl/tpc_dist_lane.sv]
module tpc_dist_lane (
    input  logic                                  clk,
    input  logic                                  en,
    input  tpc_pkg::vec_t                         p,
    input  tpc_pkg::plane_t                       plane,
    output logic signed [tpc_pkg::DIST_W-1:0]     dist_out
);
    import tpc_pkg::*;

    logic signed [PROD_W-1:0] px_reg;
    logic signed [PROD_W-1:0] py_reg;
    logic signed [PROD_W-1:0] pz_reg;
    logic signed [COORD_W-1:0] d_reg;
    logic signed [DIST_W-1:0] dist_reg;
    logic signed [DIST_W-1:0] dist_next;

    // Signed Q35.32 sum; the offset is lifted by 16 bits to match.
    always_comb
    begin
        dist_next = $signed({{(DIST_W-PROD_W){px_reg[PROD_W-1]}}, px_reg})
                  + $signed({{(DIST_W-PROD_W){py_reg[PROD_W-1]}}, py_reg})
                  + $signed({{(DIST_W-PROD_W){pz_reg[PROD_W-1]}}, pz_reg})
                  + $signed({{(DIST_W-COORD_W-16){d_reg[COORD_W-1]}}, d_reg, 16'b0});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_reg   <= plane.nx * p.x;
            py_reg   <= plane.ny * p.y;
            pz_reg   <= plane.nz * p.z;
            d_reg    <= plane.d;
            dist_reg <= dist_next;
        end
    end

    assign dist_out = dist_reg;

endmodule

[rtl/tpc_div_lane.sv]
module tpc_div_lane (
    input  logic                                  clk,
    input  logic                                  en,
    input  logic signed [tpc_pkg::DIST_W-1:0]     da,
    input  logic signed [tpc_pkg::DIST_W-1:0]     db,
    output logic [tpc_pkg::FRAC_W-1:0]            t
);
    import tpc_pkg::*;

    logic [REM_W-1:0]  r_reg   [0:DIV_STEPS];
    logic [REM_W-1:0]  den_reg [0:DIV_STEPS];
    logic [FRAC_W-1:0] t_reg   [0:DIV_STEPS];

    // Load stage: denominator da - db is positive since da >= 0 > db.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg[0]   <= {1'b0, da};
            den_reg[0] <= $unsigned($signed({da[DIST_W-1], da}) - $signed({db[DIST_W-1], db}));
            t_reg[0]   <= '0;
        end
    end

    // One restoring step per stage; the remainder always stays below den.
    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_step
        logic [REM_W-1:0] r2;
        logic             ge;

        always_comb
        begin
            r2 = {r_reg[i][REM_W-2:0], 1'b0};
            ge = (r2 >= den_reg[i]);
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[i+1]   <= ge ? (r2 - den_reg[i]) : r2;
                den_reg[i+1] <= den_reg[i];
                t_reg[i+1]   <= {t_reg[i][FRAC_W-2:0], ge};
            end
        end
    end

    assign t = t_reg[DIV_STEPS];

endmodule

[rtl/tpc_cut_lane.sv]
module tpc_cut_lane (
    input  logic                          clk,
    input  logic                          en,
    input  tpc_pkg::vec_t                 a,
    input  tpc_pkg::vec_t                 b,
    input  logic [tpc_pkg::FRAC_W-1:0]    t,
    output tpc_pkg::vec_t                 res
);
    import tpc_pkg::*;

    localparam int unsigned MUL_W = COORD_W + 1 + FRAC_W + 1;

    logic signed [MUL_W-1:0] prod_reg [3];
    vec_t                    a_reg;
    vec_t                    res_reg;
    logic signed [COORD_W:0] diff [3];

    always_comb
    begin
        diff[0] = $signed({b.x[COORD_W-1], b.x}) - $signed({a.x[COORD_W-1], a.x});
        diff[1] = $signed({b.y[COORD_W-1], b.y}) - $signed({a.y[COORD_W-1], a.y});
        diff[2] = $signed({b.z[COORD_W-1], b.z}) - $signed({a.z[COORD_W-1], a.z});
    end

    // Flooring the product is an arithmetic shift; the true result fits
    // 32 bits, so the low word of the sum is exact.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                prod_reg[i] <= MUL_W'(diff[i] * $signed({1'b0, t}));
            end
            a_reg       <= a;
            res_reg.x   <= a_reg.x + prod_reg[0][FRAC_W+COORD_W-1:FRAC_W];
            res_reg.y   <= a_reg.y + prod_reg[1][FRAC_W+COORD_W-1:FRAC_W];
            res_reg.z   <= a_reg.z + prod_reg[2][FRAC_W+COORD_W-1:FRAC_W];
        end
    end

    assign res = res_reg;

endmodule

[rtl/triangle_plane_clipper.sv]
// Channel   Dir  Handshake              Payload
// in        in   in_valid / in_ready    in0_x .. in2_z, in_colour
// out       out  out_valid / out_ready  out0_x .. out2_z, out_colour, last_piece
// cfg       in   cfg_we                 cfg_index, cfg_data
//
// An accepted triangle reaches the output register through the distance
// lanes, the classify stage, sixteen divider stages (one quotient bit
// each) and the interpolation lanes. A new triangle is taken every cycle
// while the output is not stalled; one that splits into two pieces holds
// the pipeline until its second beat is taken. Reset clears the pipeline
// valid bits and the output beat, and sets the plane registers to z >= 0.
// A stalled output freezes the whole pipeline.
module triangle_plane_clipper (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] in0_x,
    input  logic signed [31:0] in0_y,
    input  logic signed [31:0] in0_z,
    input  logic signed [31:0] in1_x,
    input  logic signed [31:0] in1_y,
    input  logic signed [31:0] in1_z,
    input  logic signed [31:0] in2_x,
    input  logic signed [31:0] in2_y,
    input  logic signed [31:0] in2_z,
    input  logic [31:0]        in_colour,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] out0_x,
    output logic signed [31:0] out0_y,
    output logic signed [31:0] out0_z,
    output logic signed [31:0] out1_x,
    output logic signed [31:0] out1_y,
    output logic signed [31:0] out1_z,
    output logic signed [31:0] out2_x,
    output logic signed [31:0] out2_y,
    output logic signed [31:0] out2_z,
    output logic [31:0]        out_colour,
    output logic               last_piece,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);
    import tpc_pkg::*;

    // Plane registers; user must write only while the block is idle; unchecked.
    plane_t plane_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_reg.nx <= '0;
            plane_reg.ny <= '0;
            plane_reg.nz <= NORMAL_Z_RESET;
            plane_reg.d  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_NORMAL_X:     plane_reg.nx <= $signed(cfg_data);
                REG_NORMAL_Y:     plane_reg.ny <= $signed(cfg_data);
                REG_NORMAL_Z:     plane_reg.nz <= $signed(cfg_data);
                REG_PLANE_OFFSET: plane_reg.d  <= $signed(cfg_data);
                default:          plane_reg.d  <= plane_reg.d;
            endcase
        end
    end

    // Every stage moves together. The pipeline advances whenever the output
    // register is empty or its final beat is being taken.
    logic adv;
    logic out_valid_reg;
    logic out_two_reg;
    logic out_phase_reg;
    logic out_last;

    assign out_last = !out_two_reg || out_phase_reg;
    assign adv      = !out_valid_reg || (out_ready && out_last);
    assign in_ready = adv;

    logic vld_reg [1:LAT];
    ctx_t ctx_reg [1:LAT];
    ctx_t ctx_in;

    always_comb
    begin
        ctx_in         = '0;
        ctx_in.vert[0] = '{x: in0_x, y: in0_y, z: in0_z};
        ctx_in.vert[1] = '{x: in1_x, y: in1_y, z: in1_z};
        ctx_in.vert[2] = '{x: in2_x, y: in2_y, z: in2_z};
        ctx_in.colour  = in_colour;
    end

    // Distance lanes, one per vertex; the result lines up with stage 2.
    logic signed [DIST_W-1:0] vdist [3];

    for (genvar v = 0; v < 3; v++)
    begin : g_dist
        tpc_dist_lane u_dist (
            .clk      (clk),
            .en       (adv),
            .p        (ctx_in.vert[v]),
            .plane    (plane_reg),
            .dist_out (vdist[v])
        );
    end

    // Classification: inside vertices and outside vertices each in vertex
    // order, and the two cut edges (inside end first) they give.
    logic [2:0] in_mask;
    ctx_t       ctx_cls;

    always_comb
    begin
        in_mask = {!vdist[2][DIST_W-1], !vdist[1][DIST_W-1], !vdist[0][DIST_W-1]};
        ctx_cls = ctx_reg[2];
        ctx_cls.a0 = 2'd0;
        ctx_cls.b0 = 2'd1;
        ctx_cls.a1 = 2'd0;
        ctx_cls.b1 = 2'd2;
        case (in_mask)
            3'b000: ctx_cls.kind = CASE_NONE;
            3'b111: ctx_cls.kind = CASE_ALL;
            3'b001:
            begin
                ctx_cls.kind = CASE_ONE;
                ctx_cls.a0 = 2'd0; ctx_cls.b0 = 2'd1; ctx_cls.a1 = 2'd0; ctx_cls.b1 = 2'd2;
            end
            3'b010:
            begin
                ctx_cls.kind = CASE_ONE;
                ctx_cls.a0 = 2'd1; ctx_cls.b0 = 2'd0; ctx_cls.a1 = 2'd1; ctx_cls.b1 = 2'd2;
            end
            3'b100:
            begin
                ctx_cls.kind = CASE_ONE;
                ctx_cls.a0 = 2'd2; ctx_cls.b0 = 2'd0; ctx_cls.a1 = 2'd2; ctx_cls.b1 = 2'd1;
            end
            3'b011:
            begin
                ctx_cls.kind = CASE_TWO;
                ctx_cls.a0 = 2'd0; ctx_cls.b0 = 2'd2; ctx_cls.a1 = 2'd1; ctx_cls.b1 = 2'd2;
            end
            3'b101:
            begin
                ctx_cls.kind = CASE_TWO;
                ctx_cls.a0 = 2'd0; ctx_cls.b0 = 2'd1; ctx_cls.a1 = 2'd2; ctx_cls.b1 = 2'd1;
            end
            3'b110:
            begin
                ctx_cls.kind = CASE_TWO;
                ctx_cls.a0 = 2'd1; ctx_cls.b0 = 2'd0; ctx_cls.a1 = 2'd2; ctx_cls.b1 = 2'd0;
            end
            default: ctx_cls.kind = CASE_NONE;
        endcase
    end

    // Context and valid line alongside the datapath lanes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 1; i <= LAT; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            vld_reg[1] <= in_valid;
            for (int i = 2; i <= LAT; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ctx_reg[1] <= ctx_in;
            ctx_reg[2] <= ctx_reg[1];
            ctx_reg[3] <= ctx_cls;
            for (int i = 4; i <= LAT; i++)
            begin
                ctx_reg[i] <= ctx_reg[i-1];
            end
        end
    end

    // Two divider lanes, one per cut edge; loaded alongside stage 3.
    logic [FRAC_W-1:0] t0;
    logic [FRAC_W-1:0] t1;

    tpc_div_lane u_div0 (
        .clk (clk),
        .en  (adv),
        .da  (vdist[ctx_cls.a0]),
        .db  (vdist[ctx_cls.b0]),
        .t   (t0)
    );

    tpc_div_lane u_div1 (
        .clk (clk),
        .en  (adv),
        .da  (vdist[ctx_cls.a1]),
        .db  (vdist[ctx_cls.b1]),
        .t   (t1)
    );

    // Interpolation lanes take their end points from the context that
    // leaves the divider together with the quotient.
    localparam int unsigned DIV_OUT = 3 + DIV_STEPS;

    vec_t c0;
    vec_t c1;

    tpc_cut_lane u_cut0 (
        .clk (clk),
        .en  (adv),
        .a   (ctx_reg[DIV_OUT].vert[ctx_reg[DIV_OUT].a0]),
        .b   (ctx_reg[DIV_OUT].vert[ctx_reg[DIV_OUT].b0]),
        .t   (t0),
        .res (c0)
    );

    tpc_cut_lane u_cut1 (
        .clk (clk),
        .en  (adv),
        .a   (ctx_reg[DIV_OUT].vert[ctx_reg[DIV_OUT].a1]),
        .b   (ctx_reg[DIV_OUT].vert[ctx_reg[DIV_OUT].b1]),
        .t   (t1),
        .res (c1)
    );

    // Merge: build up to two result triangles from the kept vertices and
    // the two cut points.
    ctx_t       ctx_last;
    tri_t       piece_a;
    tri_t       piece_b;
    logic       has_piece;
    logic       two_pieces;

    always_comb
    begin
        ctx_last   = ctx_reg[LAT];
        piece_a    = ctx_last.vert;
        piece_b[0] = ctx_last.vert[ctx_last.a1];
        piece_b[1] = c0;
        piece_b[2] = c1;
        has_piece  = 1'b1;
        two_pieces = 1'b0;
        case (ctx_last.kind)
            CASE_ALL: piece_a = ctx_last.vert;
            CASE_ONE:
            begin
                piece_a[0] = ctx_last.vert[ctx_last.a0];
                piece_a[1] = c0;
                piece_a[2] = c1;
            end
            CASE_TWO:
            begin
                piece_a[0] = ctx_last.vert[ctx_last.a0];
                piece_a[1] = ctx_last.vert[ctx_last.a1];
                piece_a[2] = c0;
                two_pieces = 1'b1;
            end
            default: has_piece = 1'b0;
        endcase
    end

    // Output register: holds both pieces; the phase bit picks the beat.
    tri_t        out_a_reg;
    tri_t        out_b_reg;
    logic [31:0] out_colour_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_two_reg   <= 1'b0;
            out_phase_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= vld_reg[LAT] && has_piece;
            out_two_reg   <= two_pieces;
            out_phase_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_phase_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_a_reg      <= piece_a;
            out_b_reg      <= piece_b;
            out_colour_reg <= ctx_last.colour;
        end
    end

    tri_t out_sel;

    assign out_sel    = out_phase_reg ? out_b_reg : out_a_reg;
    assign out_valid  = out_valid_reg;
    assign out0_x     = out_sel[0].x;
    assign out0_y     = out_sel[0].y;
    assign out0_z     = out_sel[0].z;
    assign out1_x     = out_sel[1].x;
    assign out1_y     = out_sel[1].y;
    assign out1_z     = out_sel[1].z;
    assign out2_x     = out_sel[2].x;
    assign out2_y     = out_sel[2].y;
    assign out2_z     = out_sel[2].z;
    assign out_colour = out_colour_reg;
    assign last_piece = out_last;

endmodule

[bench/tpc_checker.sv]
// Watches the input, output and register ports of the clipper, predicts
// every result triangle and compares it with what the block delivers.
module tpc_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic [9:0][31:0]  in_word,
    input  logic              out_valid,
    input  logic              out_ready,
    input  logic [10:0][31:0] out_word,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [31:0]       cfg_data,
    output int                errors,
    output int                pending,
    output int                pieces
);
    timeunit 1ns;
    timeprecision 1ps;

    import tpc_pkg::*;

    typedef logic [10:0][31:0] piece_t;

    const string field_name [11] = '{"out0_x", "out0_y", "out0_z", "out1_x", "out1_y",
        "out1_z", "out2_x", "out2_y", "out2_z", "out_colour", "last_piece"};

    logic signed [31:0] nx, ny, nz, pd;
    piece_t             piece_q [$];

    assign pending = piece_q.size();

    function automatic logic signed [79:0] plane_dist(input logic signed [31:0] v [3]);
        logic signed [79:0] s;
        s = longint'(nx) * longint'(v[0]);
        s = s + (longint'(ny) * longint'(v[1]));
        s = s + (longint'(nz) * longint'(v[2]));
        s = s + (longint'(pd) <<< 16);
        return s;
    endfunction

    // Point on the edge from inside vertex a towards outside vertex b.
    function automatic void edge_point(input logic signed [31:0] a [3],
                                       input logic signed [79:0] da,
                                       input logic signed [31:0] b [3],
                                       input logic signed [79:0] db,
                                       output logic signed [31:0] r [3]);
        logic [95:0] num, den;
        longint      t, diff;
        num = {16'b0, da} << 16;
        den = {16'b0, da - db};
        t = longint'(num / den);
        for (int i = 0; i < 3; i++)
        begin
            diff = longint'(b[i]) - longint'(a[i]);
            r[i] = 32'(longint'(a[i]) + ((diff * t) >>> 16));
        end
    endfunction

    function automatic piece_t make_piece(input logic signed [31:0] p0 [3],
                                          input logic signed [31:0] p1 [3],
                                          input logic signed [31:0] p2 [3],
                                          input logic [31:0] colour, input logic last);
        piece_t w;
        for (int i = 0; i < 3; i++)
        begin
            w[i] = p0[i];
            w[3 + i] = p1[i];
            w[6 + i] = p2[i];
        end
        w[9] = colour;
        w[10] = {31'b0, last};
        return w;
    endfunction

    function automatic void clip_triangle(input logic [9:0][31:0] w);
        logic signed [31:0] v [3][3];
        logic signed [31:0] c0 [3], c1 [3];
        logic signed [79:0] d [3];
        int                 ins [$], outs [$];
        for (int k = 0; k < 3; k++)
        begin
            for (int i = 0; i < 3; i++)
                v[k][i] = w[k * 3 + i];
            d[k] = plane_dist(v[k]);
            if (d[k] >= 0)
                ins = {ins, k};
            else
                outs = {outs, k};
        end
        case (ins.size())
            3: piece_q = {piece_q, make_piece(v[0], v[1], v[2], w[9], 1'b1)};
            1:
            begin
                edge_point(v[ins[0]], d[ins[0]], v[outs[0]], d[outs[0]], c0);
                edge_point(v[ins[0]], d[ins[0]], v[outs[1]], d[outs[1]], c1);
                piece_q = {piece_q, make_piece(v[ins[0]], c0, c1, w[9], 1'b1)};
            end
            2:
            begin
                edge_point(v[ins[0]], d[ins[0]], v[outs[0]], d[outs[0]], c0);
                edge_point(v[ins[1]], d[ins[1]], v[outs[0]], d[outs[0]], c1);
                piece_q = {piece_q, make_piece(v[ins[0]], v[ins[1]], c0, w[9], 1'b0)};
                piece_q = {piece_q, make_piece(v[ins[1]], c0, c1, w[9], 1'b1)};
            end
            default: ;
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        piece_t exp_w;
        if (!rst_n)
        begin
            nx = '0;
            ny = '0;
            nz = NORMAL_Z_RESET;
            pd = '0;
            piece_q.delete();
            errors = 0;
            pieces = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_NORMAL_X:     nx = cfg_data;
                    REG_NORMAL_Y:     ny = cfg_data;
                    REG_NORMAL_Z:     nz = cfg_data;
                    REG_PLANE_OFFSET: pd = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                clip_triangle(in_word);
            if (out_valid && out_ready)
            begin
                pieces++;
                if (piece_q.size() == 0)
                begin
                    $error("result beat arrived with nothing expected");
                    errors++;
                end
                else
                begin
                    exp_w = piece_q.pop_front();
                    for (int i = 0; i < 11; i++)
                    begin
                        if (exp_w[i] !== out_word[i])
                        begin
                            $error("%s: expected %h, got %h", field_name[i], exp_w[i],
                                   out_word[i]);
                            errors++;
                        end
                    end
                end
            end
        end
    end

endmodule

[bench/tb.sv]
// Top of the clipper bench: makes the clock, reset, register writes and
// triangle stimulus, and gives the verdict. All checking is in tpc_checker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tpc_pkg::*;

    localparam int LIMIT = 400000;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [9:0][31:0]  tri_w = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [10:0][31:0] out_w;
    logic              cfg_we = 1'b0;
    logic [1:0]        cfg_index = '0;
    logic [31:0]       cfg_data = '0;
    logic [31:0]       o0x, o0y, o0z, o1x, o1y, o1z, o2x, o2y, o2z, ocol;
    logic              olast;
    int                errors, pending, pieces;
    int                cycles = 0;
    int                sent = 0;
    // When set, neither side idles; used for the closing stretch.
    bit                quiet = 1'b0;

    always #4 clk = ~clk;

    triangle_plane_clipper u_top (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .in0_x(tri_w[0]), .in0_y(tri_w[1]), .in0_z(tri_w[2]),
        .in1_x(tri_w[3]), .in1_y(tri_w[4]), .in1_z(tri_w[5]),
        .in2_x(tri_w[6]), .in2_y(tri_w[7]), .in2_z(tri_w[8]),
        .in_colour(tri_w[9]),
        .out_valid(out_valid), .out_ready(out_ready),
        .out0_x(o0x), .out0_y(o0y), .out0_z(o0z),
        .out1_x(o1x), .out1_y(o1y), .out1_z(o1z),
        .out2_x(o2x), .out2_y(o2y), .out2_z(o2z),
        .out_colour(ocol), .last_piece(olast),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    assign out_w = {{31'b0, olast}, ocol, o2z, o2y, o2x, o1z, o1y, o1x, o0z, o0y, o0x};

    tpc_checker u_chk (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .in_word(tri_w), .out_valid(out_valid), .out_ready(out_ready),
        .out_word(out_w), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .errors(errors), .pending(pending), .pieces(pieces)
    );

    // Watchdog: a hung handshake must not run for ever.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("FAIL triangle_plane_clipper");
            $finish;
        end
    end

    // The receiver stalls in random bursts until the closing stretch.
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            if (!quiet && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge clk);
            end
        end
    end

    // One coordinate: mostly modest values so that planes cut through the
    // triangles, with full-range and boundary values mixed in.
    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 7))
            0, 1:    return $urandom();
            2:       return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
            3:       return 32'($signed($urandom_range(0, 8)) - 4);
            default: return 32'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
        endcase
    endfunction

    // Presents one triangle beat and holds it until it is accepted, then
    // perhaps leaves a random gap.
    task automatic push_triangle(input logic [9:0][31:0] w);
        in_valid <= 1'b1;
        tri_w <= w;
        do @(posedge clk); while (!in_ready);
        sent++;
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    endtask

    task automatic push_random();
        logic [9:0][31:0] w;
        for (int i = 0; i < 9; i++)
            w[i] = pick_coord();
        w[9] = $urandom();
        push_triangle(w);
    endtask

    // Lets every expected beat arrive and the pipeline empty of triangles
    // that make no result, so that the plane can safely be changed. The
    // first edge lets the checker count the last accepted triangle.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (LAT + 4) @(posedge clk);
    endtask

    task automatic write_plane(input logic [31:0] nxv, input logic [31:0] nyv,
                               input logic [31:0] nzv, input logic [31:0] dv);
        logic [31:0] val [4];
        val = '{nxv, nyv, nzv, dv};
        for (int i = 0; i < 4; i++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= 2'(i);
            cfg_data <= val[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        logic [31:0] q;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed beats against the reset plane z >= 0: all inside, none
        // inside, one and two inside, a vertex exactly on the plane, and the
        // extremes of every coordinate and of the colour.
        push_triangle({32'h0, 32'h1, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0});
        push_triangle({32'hffff_ffff, 32'hffff_ffff, 32'h0, 32'h0, 32'hffff_ffff,
                       32'h0, 32'h0, 32'hffff_ffff, 32'h0, 32'h0});
        push_triangle({32'h1234_5678, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                       32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                       32'h7fff_ffff, 32'h7fff_ffff});
        push_triangle({32'h0000_0001, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                       32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                       32'h0001_0000, 32'h7fff_ffff});
        push_triangle({32'hdead_beef, 32'hffff_0000, 32'h0003_0000, 32'h0, 32'h0002_0000,
                       32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h0});
        push_triangle({32'h5555_aaaa, 32'h0001_0000, 32'h0, 32'h0, 32'hffff_ffff,
                       32'h0, 32'h0, 32'hfffe_0000, 32'h0001_0000, 32'h0001_0000});
        push_triangle({32'haaaa_5555, 32'h8000_0000, 32'h0, 32'h0, 32'h7fff_ffff,
                       32'h0, 32'h0, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff});
        push_triangle({32'h0f0f_0f0f, 32'h0000_0005, 32'h1, 32'h2, 32'h0000_0000,
                       32'h3, 32'h4, 32'hffff_fffb, 32'h5, 32'h6});
        push_triangle({32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0});
        for (int i = 0; i < 10; i++)
            push_random();

        // Sender holds off until every expected piece is back.
        drain();

        // Phases with different planes: extremes, a zero normal either side
        // of the offset, and random planes, full range and modest.
        for (int ph = 0; ph < 8; ph++)
        begin
            drain();
            case (ph)
                0: write_plane(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
                1: write_plane(32'h0, 32'h0, 32'h0, 32'h0);
                2: write_plane(32'h0, 32'h0, 32'h0, 32'hffff_ffff);
                3: write_plane(32'h8000_0000, 32'h0, 32'h0, 32'h7fff_ffff);
                4: write_plane($urandom(), $urandom(), $urandom(), $urandom());
                default:
                begin
                    q = 32'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000);
                    write_plane(32'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000),
                                32'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000),
                                q, $urandom_range(0, 1) ? $urandom() : 32'h0);
                end
            endcase
            if (ph == 7)
                quiet = 1'b1;
            for (int i = 0; i < ((ph == 1 || ph == 2) ? 30 : 110); i++)
                push_random();
        end

        drain();
        repeat (6) @(posedge clk);

        $display("Sent %0d triangles through nine plane settings; %0d result pieces checked.",
                 sent, pieces);
        if (errors == 0 && pending == 0)
            $display("PASS triangle_plane_clipper");
        else
            $display("FAIL triangle_plane_clipper");
        $finish;
    end

endmodule
